FILE: src/wsrwf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsrwf_pkg: shared types and constants for the wheel slip window filter
// Register indexes, controller states and controller/datapath command struct.
// ----------------------------------------------------------------------------
package wsrwf_pkg;

  localparam int MaxWindow = 16;
  localparam int SlotW     = $clog2(MaxWindow);
  localparam int CountW    = $clog2(MaxWindow + 1);
  localparam logic [16:0] OneQ15 = 17'd32768;

  localparam logic [2:0] REG_LINEAR_FLOOR  = 3'd0;
  localparam logic [2:0] REG_ANGULAR_FLOOR = 3'd1;
  localparam logic [2:0] REG_FULL_CONF     = 3'd2;
  localparam logic [2:0] REG_WINDOW_LENGTH = 3'd3;
  localparam logic [2:0] REG_SLIP_LIMIT    = 3'd4;

  // Divider operand select
  typedef enum logic [2:0] {
    DIV_LIN, DIV_TURN, DIV_CONF, DIV_MLIN, DIV_MTURN, DIV_MCONF
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_START, ST_DIV_WAIT, ST_WRITE, ST_ACC_START, ST_ACC,
    ST_MEAN_START, ST_MEAN_WAIT, ST_OUT
  } ctl_state_t;

  typedef struct packed {
    logic     capture;    // latch input word
    logic     div_start;  // launch divider
    div_sel_t div_sel;    // which quotient
    logic     div_store;  // store quotient for div_sel
    logic     hist_write; // push sample into history
    logic     acc_clear;  // clear window sums
    logic     acc_step;   // add one history entry
    logic     out_load;   // load output register
  } ctl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic acc_last;
    logic mean_zero;
  } dp_status_t;

endpackage

FILE: src/wsrwf_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsrwf_divider: restoring radix-2 divider
// Unsigned 48/33 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wsrwf_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [47:0] quotient
);

  logic [47:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [32:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [33:0] trial;

  // One shift-subtract step per cycle
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, quo_r[47]} - {1'b0, dvs_r};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = 6'd48;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        quo_nxt = {quo_r[46:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], quo_r[47]};
        quo_nxt = {quo_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign done     = busy_r && (cnt_r == 6'd1);
  assign quotient = quo_nxt;

endmodule

FILE: src/wsrwf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsrwf_datapath: slip ratio arithmetic, history memory and window sums
// Holds the registers, the sample history and one shared divider.
// ----------------------------------------------------------------------------
module wsrwf_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic signed [15:0]  in_wheel_speed,
  input  logic signed [15:0]  in_inertial_speed,
  input  logic signed [15:0]  in_wheel_turn_rate,
  input  logic signed [15:0]  in_inertial_turn_rate,
  input  logic [31:0]         in_sample_time,
  input  wsrwf_pkg::ctl_cmd_t cmd,
  output wsrwf_pkg::dp_status_t status,
  output logic [15:0]         out_linear_slip,
  output logic [15:0]         out_turning_slip,
  output logic [15:0]         out_sample_confidence,
  output logic [15:0]         out_mean_linear_slip,
  output logic [15:0]         out_mean_turning_slip,
  output logic [15:0]         out_mean_confidence,
  output logic [31:0]         out_latest_time,
  output logic                out_slipping
);

  localparam int SW = wsrwf_pkg::SlotW;
  localparam int CW = wsrwf_pkg::CountW;

  logic [14:0] lin_floor_r, ang_floor_r, full_conf_r;
  logic [4:0]  win_len_r;
  logic [15:0] slip_limit_r;
  logic [CW-1:0] count_r, count_nxt, eff_win, eff_cfg;
  logic [SW-1:0] newest_r, rd_slot_r;
  logic [CW-1:0] acc_left_r;

  logic signed [15:0] a0_r, b0_r, a1_r, b1_r;
  logic [31:0] time_r;

  logic [47:0] hist_mem [wsrwf_pkg::MaxWindow];
  logic [47:0] rd_data_r;
  logic        rd_vld_r;

  logic [15:0] lin_r, turn_r, conf_r, mlin_r, mturn_r, mconf_r;
  logic [36:0] acc_lin_r, acc_turn_r;
  logic [20:0] acc_conf_r;
  logic [31:0] prod_lin_r, prod_turn_r;
  logic [15:0] prod_conf_r;
  logic        prod_vld_r;

  logic [47:0] div_num;
  logic [32:0] div_den;
  logic        div_zero;
  logic        div_done;
  logic [47:0] div_q;
  logic [16:0] q_sat;

  // Clamp a window length to 1..MaxWindow
  function automatic logic [CW-1:0] clamp_win(input logic [4:0] w);
    logic [CW-1:0] r;
    if (w == 5'd0) begin
      r = CW'(1);
    end else if (32'(w) > wsrwf_pkg::MaxWindow) begin
      r = CW'(wsrwf_pkg::MaxWindow);
    end else begin
      r = CW'(w);
    end
    return r;
  endfunction

  function automatic logic [16:0] abs16(input logic signed [15:0] v);
    logic [16:0] r;
    r = v[15] ? 17'(-$signed({v[15], v})) : {1'b0, v};
    return r;
  endfunction

  assign eff_win = clamp_win(win_len_r);
  assign eff_cfg = clamp_win(cfg_data[4:0]);

  // Operand preparation for the shared divider
  logic [16:0] abs_a0, abs_b0, abs_a1, abs_b1;
  logic [17:0] sum0, sum1, dif0, dif1;
  logic signed [17:0] d0s, d1s;
  logic        zero0, zero1;
  assign abs_a0 = abs16(a0_r);
  assign abs_b0 = abs16(b0_r);
  assign abs_a1 = abs16(a1_r);
  assign abs_b1 = abs16(b1_r);
  assign sum0   = {1'b0, abs_a0} + {1'b0, abs_b0};
  assign sum1   = {1'b0, abs_a1} + {1'b0, abs_b1};
  assign d0s    = 18'(a0_r) - 18'(b0_r);
  assign d1s    = 18'(a1_r) - 18'(b1_r);
  assign dif0   = d0s[17] ? 18'(-d0s) : 18'(d0s);
  assign dif1   = d1s[17] ? 18'(-d1s) : 18'(d1s);
  assign zero0  = (sum0 < {2'b0, lin_floor_r, 1'b0}) || (sum0 == '0);
  assign zero1  = (sum1 < {2'b0, ang_floor_r, 1'b0}) || (sum1 == '0);

  always_comb begin
    div_num  = '0;
    div_den  = 33'd1;
    div_zero = 1'b0;
    unique case (cmd.div_sel)
      wsrwf_pkg::DIV_LIN: begin
        div_num  = {14'b0, dif0, 16'b0};
        div_den  = 33'(sum0);
        div_zero = zero0;
      end
      wsrwf_pkg::DIV_TURN: begin
        div_num  = {14'b0, dif1, 16'b0};
        div_den  = 33'(sum1);
        div_zero = zero1;
      end
      wsrwf_pkg::DIV_CONF: begin
        div_num  = {15'b0, sum0, 15'b0};
        div_den  = {17'b0, full_conf_r, 1'b0};
        div_zero = (full_conf_r == '0);
      end
      wsrwf_pkg::DIV_MLIN: begin
        div_num  = 48'(acc_lin_r);
        div_den  = 33'(acc_conf_r);
      end
      wsrwf_pkg::DIV_MTURN: begin
        div_num  = 48'(acc_turn_r);
        div_den  = 33'(acc_conf_r);
      end
      wsrwf_pkg::DIV_MCONF: begin
        div_num  = 48'(acc_conf_r);
        div_den  = 33'(count_r);
      end
      default: begin
        div_num  = '0;
      end
    endcase
    if (div_den == '0) begin
      div_den = 33'd1;
    end
  end

  wsrwf_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_sat = (div_q > 48'(wsrwf_pkg::OneQ15)) ? wsrwf_pkg::OneQ15 : div_q[16:0];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_floor_r  <= 15'd26;
      ang_floor_r  <= 15'd13;
      full_conf_r  <= 15'd256;
      win_len_r    <= 5'd10;
      slip_limit_r <= 16'd6554;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        wsrwf_pkg::REG_LINEAR_FLOOR:  lin_floor_r  <= cfg_data[14:0];
        wsrwf_pkg::REG_ANGULAR_FLOOR: ang_floor_r  <= cfg_data[14:0];
        wsrwf_pkg::REG_FULL_CONF:     full_conf_r  <= cfg_data[14:0];
        wsrwf_pkg::REG_WINDOW_LENGTH: win_len_r    <= cfg_data[4:0];
        wsrwf_pkg::REG_SLIP_LIMIT:    slip_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Entry count: grow on push, trim on window shrink
  always_comb begin
    count_nxt = count_r;
    if (cfg_wr_en && cfg_index == wsrwf_pkg::REG_WINDOW_LENGTH && count_r > eff_cfg) begin
      count_nxt = eff_cfg;
    end else if (cmd.hist_write && count_r < eff_win) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      newest_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (cmd.hist_write) begin
        newest_r <= newest_r + SW'(1);
      end
    end
  end

  // Capture sample and quotients
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      a0_r   <= in_wheel_speed;
      b0_r   <= in_inertial_speed;
      a1_r   <= in_wheel_turn_rate;
      b1_r   <= in_inertial_turn_rate;
      time_r <= in_sample_time;
    end
    if (cmd.div_store) begin
      unique case (cmd.div_sel)
        wsrwf_pkg::DIV_LIN:   lin_r   <= div_zero ? 16'd0 : q_sat[15:0];
        wsrwf_pkg::DIV_TURN:  turn_r  <= div_zero ? 16'd0 : q_sat[15:0];
        wsrwf_pkg::DIV_CONF:  conf_r  <= div_zero ? 16'h8000 : q_sat[15:0];
        wsrwf_pkg::DIV_MLIN:  mlin_r  <= div_q[15:0];
        wsrwf_pkg::DIV_MTURN: mturn_r <= div_q[15:0];
        wsrwf_pkg::DIV_MCONF: mconf_r <= div_q[15:0];
        default: ;
      endcase
    end
  end

  // History memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.hist_write) begin
      hist_mem[newest_r + SW'(1)] <= {lin_r, turn_r, conf_r};
    end
    rd_data_r <= hist_mem[rd_slot_r];
  end

  // Walk the window newest to oldest: read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
      acc_left_r <= '0;
    end else begin
      if (cmd.acc_clear) begin
        rd_slot_r  <= newest_r;
        acc_left_r <= count_r;
        rd_vld_r   <= 1'b0;
        prod_vld_r <= 1'b0;
      end else begin
        rd_vld_r   <= cmd.acc_step && (acc_left_r != '0);
        prod_vld_r <= rd_vld_r;
        if (cmd.acc_step && acc_left_r != '0) begin
          rd_slot_r  <= rd_slot_r - SW'(1);
          acc_left_r <= acc_left_r - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_lin_r  <= rd_data_r[47:32] * rd_data_r[15:0];
    prod_turn_r <= rd_data_r[31:16] * rd_data_r[15:0];
    prod_conf_r <= rd_data_r[15:0];
    if (cmd.acc_clear) begin
      acc_lin_r  <= '0;
      acc_turn_r <= '0;
      acc_conf_r <= '0;
    end else if (prod_vld_r) begin
      acc_lin_r  <= acc_lin_r + 37'(prod_lin_r);
      acc_turn_r <= acc_turn_r + 37'(prod_turn_r);
      acc_conf_r <= acc_conf_r + 21'(prod_conf_r);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_linear_slip       <= lin_r;
      out_turning_slip      <= turn_r;
      out_sample_confidence <= conf_r;
      out_mean_linear_slip  <= status.mean_zero ? 16'd0 : mlin_r;
      out_mean_turning_slip <= status.mean_zero ? 16'd0 : mturn_r;
      out_mean_confidence   <= status.mean_zero ? 16'd0 : mconf_r;
      out_latest_time       <= time_r;
      out_slipping          <= !status.mean_zero &&
                               ((mlin_r > slip_limit_r) || (mturn_r > slip_limit_r));
    end
  end

  assign status.div_done  = div_done;
  assign status.acc_last  = (acc_left_r == '0) && !rd_vld_r && !prod_vld_r;
  assign status.mean_zero = (acc_conf_r == '0) || (count_r == '0);

endmodule

FILE: src/wsrwf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsrwf_ctrl: sequencing controller
// Steps each word through the divisions, history push, window sum and output.
// ----------------------------------------------------------------------------
module wsrwf_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  wsrwf_pkg::dp_status_t  status,
  output wsrwf_pkg::ctl_cmd_t    cmd
);

  wsrwf_pkg::ctl_state_t state_r, state_nxt;
  wsrwf_pkg::div_sel_t   sel_r, sel_nxt;
  logic                  ovld_r, ovld_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wsrwf_pkg::ST_IDLE;
      sel_r   <= wsrwf_pkg::DIV_LIN;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    ovld_nxt  = ovld_r && out_stall;
    cmd       = '0;
    cmd.div_sel = sel_r;
    in_stall  = 1'b1;
    unique case (state_r)
      wsrwf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          sel_nxt     = wsrwf_pkg::DIV_LIN;
          state_nxt   = wsrwf_pkg::ST_DIV_START;
        end
      end
      wsrwf_pkg::ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = wsrwf_pkg::ST_DIV_WAIT;
      end
      wsrwf_pkg::ST_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          if (sel_r == wsrwf_pkg::DIV_CONF) begin
            state_nxt = wsrwf_pkg::ST_WRITE;
          end else begin
            sel_nxt   = (sel_r == wsrwf_pkg::DIV_LIN) ? wsrwf_pkg::DIV_TURN
                                                      : wsrwf_pkg::DIV_CONF;
            state_nxt = wsrwf_pkg::ST_DIV_START;
          end
        end
      end
      wsrwf_pkg::ST_WRITE: begin
        cmd.hist_write = 1'b1;
        state_nxt      = wsrwf_pkg::ST_ACC_START;
      end
      wsrwf_pkg::ST_ACC_START: begin
        cmd.acc_clear = 1'b1;
        state_nxt     = wsrwf_pkg::ST_ACC;
      end
      wsrwf_pkg::ST_ACC: begin
        cmd.acc_step = 1'b1;
        if (status.acc_last) begin
          sel_nxt   = wsrwf_pkg::DIV_MLIN;
          state_nxt = wsrwf_pkg::ST_MEAN_START;
        end
      end
      wsrwf_pkg::ST_MEAN_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = wsrwf_pkg::ST_MEAN_WAIT;
      end
      wsrwf_pkg::ST_MEAN_WAIT: begin
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          if (sel_r == wsrwf_pkg::DIV_MCONF) begin
            state_nxt = wsrwf_pkg::ST_OUT;
          end else begin
            sel_nxt   = (sel_r == wsrwf_pkg::DIV_MLIN) ? wsrwf_pkg::DIV_MTURN
                                                       : wsrwf_pkg::DIV_MCONF;
            state_nxt = wsrwf_pkg::ST_MEAN_START;
          end
        end
      end
      wsrwf_pkg::ST_OUT: begin
        // wait for the output register to free up
        if (!ovld_r || !out_stall) begin
          cmd.out_load = 1'b1;
          ovld_nxt     = 1'b1;
          state_nxt    = wsrwf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wsrwf_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = ovld_r;

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!ovld_r || !out_stall))
    else $error("output word overwritten while stalled");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == wsrwf_pkg::ST_DIV_START))
    else $error("accepted word did not start division");
  a_push_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hist_write |=> !cmd.hist_write)
    else $error("history pushed twice");
`endif

endmodule

FILE: src/wheel_slip_ratio_window_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_slip_ratio_window_filter: slip ratio with confidence-weighted window
// Top level joining the sequencing controller and the arithmetic datapath.
// ----------------------------------------------------------------------------
// Per word: six divisions on one shared radix-2 divider, one history write,
//   one clear, a window walk over the N entries in the window (N = 1..16)
//   and one load.
// The next word is taken while the result waits in the output register,
//   and a held result delays the load.
// Reset: synchronous active-low; configuration registers return to defaults, window empty.
module wheel_slip_ratio_window_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_wheel_speed,
  input  logic signed [15:0] in_inertial_speed,
  input  logic signed [15:0] in_wheel_turn_rate,
  input  logic signed [15:0] in_inertial_turn_rate,
  input  logic [31:0]        in_sample_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_linear_slip,
  output logic [15:0]        out_turning_slip,
  output logic [15:0]        out_sample_confidence,
  output logic [15:0]        out_mean_linear_slip,
  output logic [15:0]        out_mean_turning_slip,
  output logic [15:0]        out_mean_confidence,
  output logic [31:0]        out_latest_time,
  output logic               out_slipping
);

  wsrwf_pkg::ctl_cmd_t   cmd;
  wsrwf_pkg::dp_status_t status;

  wsrwf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  wsrwf_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_wheel_speed        (in_wheel_speed),
    .in_inertial_speed     (in_inertial_speed),
    .in_wheel_turn_rate    (in_wheel_turn_rate),
    .in_inertial_turn_rate (in_inertial_turn_rate),
    .in_sample_time        (in_sample_time),
    .cmd                   (cmd),
    .status                (status),
    .out_linear_slip       (out_linear_slip),
    .out_turning_slip      (out_turning_slip),
    .out_sample_confidence (out_sample_confidence),
    .out_mean_linear_slip  (out_mean_linear_slip),
    .out_mean_turning_slip (out_mean_turning_slip),
    .out_mean_confidence   (out_mean_confidence),
    .out_latest_time       (out_latest_time),
    .out_slipping          (out_slipping)
  );

endmodule
